@@ rtl/mrhc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrhc_pkg
// Shared types, constants and the power divisor table for the mains ripple
// heater correction block.
// ----------------------------------------------------------------------------
package mrhc_pkg;

  localparam int SampleBitsDef = 10;
  localparam int SampleW       = 10;
  localparam int AmpW          = 10;
  localparam int PwrW          = 7;
  localparam int NoSensorLimit = 50;
  localparam int NoSensorAmp   = 230;
  localparam int FullPower     = 100;
  localparam int AmpMax        = 1023;
  localparam int RatioDivisor  = 23;
  // ceil(2^15 * 2560 / 23), exact floor(amp * 2560 / 23) for amp up to 1023
  localparam int RatioRecip    = 3647221;
  localparam int RatioShift    = 15;
  localparam int ProdW         = 32;
  localparam int FullQ8        = 25600;
  localparam int DivW          = 22;
  localparam int DivSteps      = 22;
  localparam int CntW          = $clog2(DivSteps);
  localparam int RemW          = 7;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [AmpW-1:0] amplitude;
    logic [PwrW-1:0] corrected_power;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AMP,
    ST_RATIO,
    ST_DELTA_LOAD,
    ST_DELTA,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic sample_en;
    logic amp_load;
    logic ratio_load;
    logic div_step;
    logic delta_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
  } dp_sts_t;

  // floor(100 / power) for 1..99, one elsewhere
  function automatic logic [RemW-1:0] power_divisor(input logic [PwrW-1:0] pwr);
    logic [RemW-1:0] res;
    if (pwr == '0 || pwr >= PwrW'(FullPower)) res = 7'd1;
    else if (pwr >= 7'd51) res = 7'd1;
    else if (pwr >= 7'd34) res = 7'd2;
    else if (pwr >= 7'd26) res = 7'd3;
    else if (pwr >= 7'd21) res = 7'd4;
    else if (pwr >= 7'd17) res = 7'd5;
    else if (pwr >= 7'd15) res = 7'd6;
    else if (pwr >= 7'd13) res = 7'd7;
    else if (pwr == 7'd12) res = 7'd8;
    else if (pwr == 7'd11) res = 7'd9;
    else if (pwr == 7'd10) res = 7'd10;
    else if (pwr == 7'd9)  res = 7'd11;
    else if (pwr == 7'd8)  res = 7'd12;
    else if (pwr == 7'd7)  res = 7'd14;
    else if (pwr == 7'd6)  res = 7'd16;
    else if (pwr == 7'd5)  res = 7'd20;
    else if (pwr == 7'd4)  res = 7'd25;
    else if (pwr == 7'd3)  res = 7'd33;
    else if (pwr == 7'd2)  res = 7'd50;
    else                   res = 7'd100;
    return res;
  endfunction

endpackage

@@ rtl/mains_ripple_heater_correction_top.sv @@
// ----------------------------------------------------------------------------
// mains_ripple_heater_correction_top
// Tracks the mains-sense window min and max and gives the peak-to-peak
// amplitude with the heater power corrected for it at each window end.
// ----------------------------------------------------------------------------
// An item without the last flag is taken whenever the block is idle, and items may
// follow back to back. An item with the last flag holds the input while the block forms
// the amplitude, scales it by 1/2.3 with a constant reciprocal multiply, forms the
// signed delta, runs 22 steps of a restoring divider for the division by
// floor(100/power) and loads the output register; the last of these waits as long
// as an earlier result still sits unaccepted in the output register. The result
// then waits in the output register while new items are taken.
module mains_ripple_heater_correction_top #(
  parameter int SampleBits = mrhc_pkg::SampleBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mrhc_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mrhc_pkg::out_item_t       out_item_o,
  input  logic                      cfg_we_i,
  input  logic [mrhc_pkg::PwrW-1:0] cfg_wdata_i
);

  mrhc_pkg::dp_cmd_t cmd;
  mrhc_pkg::dp_sts_t sts;

  mrhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mrhc_dp #(
    .SampleBits (SampleBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/mrhc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrhc_ctrl
// Sequencer: takes items, runs the correction steps at each window end and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module mrhc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mrhc_pkg::dp_cmd_t cmd_o,
  input  mrhc_pkg::dp_sts_t sts_i
);

  mrhc_pkg::ctl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic slot_free;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mrhc_pkg::ST_IDLE: begin
        if (accept && in_last_i) state_d = mrhc_pkg::ST_AMP;
      end
      mrhc_pkg::ST_AMP: begin
        state_d = mrhc_pkg::ST_RATIO;
      end
      mrhc_pkg::ST_RATIO: begin
        state_d = mrhc_pkg::ST_DELTA_LOAD;
      end
      mrhc_pkg::ST_DELTA_LOAD: begin
        state_d = mrhc_pkg::ST_DELTA;
      end
      mrhc_pkg::ST_DELTA: begin
        if (sts_i.step_last) state_d = mrhc_pkg::ST_FINISH;
      end
      mrhc_pkg::ST_FINISH: begin
        if (slot_free) state_d = mrhc_pkg::ST_IDLE;
      end
      default: begin
        state_d = mrhc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      mrhc_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.sample_en = in_valid_i;
      end
      mrhc_pkg::ST_AMP: begin
        cmd_o.amp_load = 1'b1;
      end
      mrhc_pkg::ST_RATIO: begin
        cmd_o.ratio_load = 1'b1;
      end
      mrhc_pkg::ST_DELTA_LOAD: begin
        cmd_o.delta_load = 1'b1;
      end
      mrhc_pkg::ST_DELTA: begin
        cmd_o.div_step = 1'b1;
      end
      mrhc_pkg::ST_FINISH: begin
        cmd_o.out_load = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrhc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending one");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (state_q == mrhc_pkg::ST_AMP))
    else $error("window end did not start the correction");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.out_load))
    else $error("result valid without a load");

endmodule

@@ rtl/mrhc_dp.sv @@
// ----------------------------------------------------------------------------
// mrhc_dp
// Datapath: window min and max, amplitude, reciprocal scaling by 1/2.3,
// restoring divider, correction sum and the output register.
// ----------------------------------------------------------------------------
module mrhc_dp #(
  parameter int SampleBits = mrhc_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mrhc_pkg::dp_cmd_t             cmd_i,
  output mrhc_pkg::dp_sts_t             sts_o,
  input  mrhc_pkg::in_item_t            in_item_i,
  input  logic                          cfg_we_i,
  input  logic [mrhc_pkg::PwrW-1:0]     cfg_wdata_i,
  output mrhc_pkg::out_item_t           out_item_o
);

  localparam int AmpW       = mrhc_pkg::AmpW;
  localparam int PwrW       = mrhc_pkg::PwrW;
  localparam int DivW       = mrhc_pkg::DivW;
  localparam int RemW       = mrhc_pkg::RemW;
  localparam int CntW       = mrhc_pkg::CntW;
  localparam int ProdW      = mrhc_pkg::ProdW;
  localparam int RatioShift = mrhc_pkg::RatioShift;
  localparam int WideW      = (SampleBits > AmpW) ? SampleBits : AmpW;

  logic [SampleBits:0]   win_min_q;
  logic [SampleBits-1:0] win_max_q;
  logic [SampleBits-1:0] smp;
  logic [PwrW-1:0]       pwr_q;
  logic [AmpW-1:0]       amp_q;
  logic [DivW-1:0]       n_q, n_d;
  logic [RemW-1:0]       r_q, r_d;
  logic [RemW-1:0]       d_q;
  logic                  neg_q;
  logic [CntW-1:0]       cnt_q;
  mrhc_pkg::out_item_t   out_q;

  logic [SampleBits-1:0] diff;
  logic [WideW-1:0]      diff_w;
  logic [AmpW-1:0]       amp_sat, amp_calc;
  logic [ProdW-1:0]      ratio_prod;
  logic [RemW:0]         trial;
  logic                  ge;
  logic signed [DivW:0]  delta_s, delta_mag;
  logic signed [23:0]    quot_s, sum_s;
  logic [PwrW-1:0]       corr;

  assign smp = SampleBits'(in_item_i.sample);

  assign diff     = win_max_q - win_min_q[SampleBits-1:0];
  assign diff_w   = WideW'(diff);
  assign amp_sat  = (diff_w > WideW'(mrhc_pkg::AmpMax)) ? AmpW'(mrhc_pkg::AmpMax)
                                                        : diff_w[AmpW-1:0];
  assign amp_calc = (amp_sat < AmpW'(mrhc_pkg::NoSensorLimit)) ?
                    AmpW'(mrhc_pkg::NoSensorAmp) : amp_sat;

  // amp / 2.3 in q8
  assign ratio_prod = ProdW'(amp_q) * ProdW'(mrhc_pkg::RatioRecip);

  // one restoring step
  assign trial = {r_q, n_q[DivW-1]};
  assign ge    = trial >= {1'b0, d_q};
  always_comb begin
    if (ge) r_d = RemW'(trial - {1'b0, d_q});
    else    r_d = trial[RemW-1:0];
    n_d = {n_q[DivW-2:0], ge};
  end

  assign delta_s   = $signed((DivW+1)'(mrhc_pkg::FullQ8)) - $signed({1'b0, n_q});
  assign delta_mag = delta_s[DivW] ? -delta_s : delta_s;

  assign quot_s = neg_q ? -$signed({2'b00, n_q}) : $signed({2'b00, n_q});
  assign sum_s  = $signed({9'd0, pwr_q, 8'd0}) + quot_s;

  always_comb begin
    if (pwr_q >= PwrW'(mrhc_pkg::FullPower))    corr = PwrW'(mrhc_pkg::FullPower);
    else if (pwr_q == '0)                       corr = '0;
    else if (sum_s > 24'sd25600)                corr = PwrW'(mrhc_pkg::FullPower);
    else if (sum_s < 24'sd0)                    corr = '0;
    else                                        corr = sum_s[14:8];
  end

  assign sts_o.step_last = (cnt_q == CntW'(mrhc_pkg::DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_min_q <= (SampleBits+1)'(1) << SampleBits;
      win_max_q <= '0;
      pwr_q     <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) pwr_q <= cfg_wdata_i;
      if (cmd_i.sample_en) begin
        if ({1'b0, smp} < win_min_q) win_min_q <= {1'b0, smp};
        if (smp > win_max_q) win_max_q <= smp;
      end
      if (cmd_i.amp_load) begin
        win_min_q <= (SampleBits+1)'(1) << SampleBits;
        win_max_q <= '0;
      end
      if (cmd_i.amp_load || cmd_i.delta_load) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.amp_load) begin
      amp_q <= amp_calc;
    end else if (cmd_i.ratio_load) begin
      n_q   <= DivW'(ratio_prod[ProdW-1:RatioShift]);
    end else if (cmd_i.delta_load) begin
      n_q   <= delta_mag[DivW-1:0];
      neg_q <= delta_s[DivW];
      r_q   <= '0;
      d_q   <= mrhc_pkg::power_divisor(pwr_q);
    end else if (cmd_i.div_step) begin
      n_q <= n_d;
      r_q <= r_d;
    end
    if (cmd_i.out_load) begin
      out_q.amplitude       <= amp_q;
      out_q.corrected_power <= corr;
    end
  end

  assign out_item_o = out_q;

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sample_en |=> (win_min_q <= {1'b0, win_max_q}))
    else $error("window minimum above maximum");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (r_q < d_q))
    else $error("divider remainder not below divisor");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (out_q.corrected_power <= PwrW'(mrhc_pkg::FullPower)))
    else $error("corrected power out of range");

endmodule
